// ===== rtl/rip_relative_reference_scan_unit_assert.svh =====
// Assertion macros for the RIP-relative reference scan unit.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef RIP_RELATIVE_REFERENCE_SCAN_UNIT_ASSERT_SVH
`define RIP_RELATIVE_REFERENCE_SCAN_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRS_ASSERT(lbl, prop, msg)
`define RRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/rrs_pkg.sv =====
// Shared types and constants of the RIP-relative reference scan unit.
// No dependencies.
package rrs_pkg;

  localparam int POS_BITS_DEF  = 32;
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int WINDOW_LAG    = 6;   // bytes held before the current one
  localparam int INSTR_LEN     = 7;

  localparam logic [7:0] REX_W      = 8'h48;
  localparam logic [7:0] REX_WR     = 8'h4C;
  localparam logic [7:0] OPC_LEA    = 8'h8D;
  localparam logic [7:0] OPC_MOV    = 8'h8B;
  localparam logic [1:0] MODRM_MOD0 = 2'b00;
  localparam logic [2:0] MODRM_RIP  = 3'd5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCAN_MODE    = 3'd0,
    REG_REGION_BASE  = 3'd1,
    REG_MATCH_TARGET = 3'd2,
    REG_RANGE_BASE   = 3'd3,
    REG_RANGE_SIZE   = 3'd4,
    REG_NTH_INDEX    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        scan_mode;
    logic [63:0] region_base;
    logic [63:0] match_target;
    logic [63:0] range_base;
    logic [31:0] range_size;
    logic [15:0] nth_index;
  } cfg_t;

  // request from front to back: a decoded candidate or an end of stream
  typedef struct packed {
    logic        is_end;
    logic [63:0] ia;
    logic [31:0] disp;
  } mid_entry_t;

  typedef struct packed {
    logic        found;
    logic [63:0] instr_address;
    logic [63:0] target_address;
  } res_t;

endpackage

// ===== rtl/rrs_fifo.sv =====
// Small register-based FIFO used between front and back and at the output.
// Depends on rip_relative_reference_scan_unit_assert.svh.
`include "rip_relative_reference_scan_unit_assert.svh"

module rrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4   // power of two
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == (AW + 1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_comb begin
    case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  `RRS_ASSERT(a_no_push_full, !(push && full), "fifo push while full")
  `RRS_ASSERT(a_not_empty_and_full, !(empty && full), "fifo empty and full at once")
  `RRS_ASSERT_ALWAYS(a_cnt_range, !rst_n || cnt_r <= (AW + 1)'(DEPTH), "fifo count past depth")

endmodule

// ===== rtl/rrs_front.sv =====
// Front part: byte window, stream position and instruction pattern decode.
// Depends on rrs_pkg.
module rrs_front import rrs_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] code_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output logic       ent_push,
  output mid_entry_t ent
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [POSITION_BITS-1:0] Lag    = POSITION_BITS'(WINDOW_LAG);

  logic [47:0]              win_r, win_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]               rex, opc, modrm;
  logic                     check, rex_ok, opc_ok, rip_ok;

  assign rex   = win_r[7:0];
  assign opc   = win_r[15:8];
  assign modrm = win_r[23:16];

  // last byte never closes a checked window; saturated position stops checks
  assign check  = !last_byte && (pos_r >= Lag) && (pos_r != PosMax);
  assign rex_ok = (rex == REX_W) || (rex == REX_WR);
  assign opc_ok = (opc == OPC_LEA) || (cfg.scan_mode && (opc == OPC_MOV));
  assign rip_ok = (modrm[7:6] == MODRM_MOD0) && (modrm[2:0] == MODRM_RIP);

  assign ent_push   = accept && (last_byte || (check && rex_ok && opc_ok && rip_ok));
  assign ent.is_end = last_byte;
  assign ent.ia     = cfg.region_base + 64'(pos_r - Lag);
  assign ent.disp   = {code_byte, win_r[47:24]};

  always_comb begin
    win_nxt = win_r;
    pos_nxt = pos_r;
    if (accept) begin
      if (last_byte) begin
        win_nxt = '0;
        pos_nxt = '0;
      end else begin
        win_nxt = {code_byte, win_r[47:8]};
        if (pos_r != PosMax) pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      pos_r <= '0;
    end else begin
      win_r <= win_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/rrs_back.sv =====
// Back part: target add, range/exact compare, hit counting, per-stream result.
// Depends on rrs_pkg and rip_relative_reference_scan_unit_assert.svh.
`include "rip_relative_reference_scan_unit_assert.svh"

module rrs_back import rrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       ent_avail,
  input  mid_entry_t ent,
  output logic       ent_pop,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res
);

  // stage A: entry from queue; stage B: computed target
  logic        a_valid_r;
  mid_entry_t  a_ent_r;
  logic        b_valid_r, b_end_r;
  logic [63:0] b_ia_r, b_tg_r;
  logic        done_r, done_nxt;
  logic [15:0] count_r, count_nxt;

  logic        adv, in_range, exact, hit;
  logic [63:0] tg_a, off;

  assign adv     = !res_full;
  assign ent_pop = adv && ent_avail;

  assign tg_a = a_ent_r.ia + {{32{a_ent_r.disp[31]}}, a_ent_r.disp} + 64'(INSTR_LEN);

  assign off      = b_tg_r - cfg.range_base;
  assign in_range = off < {32'd0, cfg.range_size};
  assign exact    = b_tg_r == cfg.match_target;
  assign hit      = cfg.scan_mode ? (in_range && (count_r == cfg.nth_index)) : exact;

  always_comb begin
    res_push  = 1'b0;
    res       = '0;
    done_nxt  = done_r;
    count_nxt = count_r;
    if (adv && b_valid_r) begin
      if (b_end_r) begin
        res_push  = !done_r;
        done_nxt  = 1'b0;
        count_nxt = '0;
      end else if (!done_r) begin
        if (hit) begin
          res_push           = 1'b1;
          res.found          = 1'b1;
          res.instr_address  = b_ia_r;
          res.target_address = b_tg_r;
          done_nxt           = 1'b1;
        end else if (cfg.scan_mode && in_range) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ent_r <= ent;
      b_end_r <= a_ent_r.is_end;
      b_ia_r  <= a_ent_r.ia;
      b_tg_r  <= tg_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      done_r    <= 1'b0;
      count_r   <= '0;
    end else begin
      if (adv) begin
        a_valid_r <= ent_avail;
        b_valid_r <= a_valid_r;
      end
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
  end

  `RRS_ASSERT(a_push_needs_stage, res_push |-> (b_valid_r && !res_full), "result without work")
  `RRS_ASSERT(a_one_hit, (res_push && res.found) |-> !done_r, "second hit in a stream")
  `RRS_ASSERT(a_done_after_hit, (res_push && res.found) |=> done_r, "hit did not close stream")
  `RRS_ASSERT(a_end_clears, (adv && b_valid_r && b_end_r) |=> (!done_r && count_r == '0),
              "stream end left state")

endmodule

// ===== rtl/rip_relative_reference_scan_unit.sv =====
// Top level of the RIP-relative reference scan unit: config registers,
// front decode, request queue, back compare and result queue.
// Candidates pass the request queue and back stages A and B; results the result queue.
// Throughput: one code byte per cycle; in_full rises only when the result
// queue is full and the 4-entry request queue has filled behind it.
// Reset (rst_n low, synchronous) clears config registers, stream state and queues.
module rip_relative_reference_scan_unit import rrs_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [7:0]              in_code_byte,
  input  logic                    in_last_byte,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic                    out_found,
  output logic [63:0]             out_instr_address,
  output logic [63:0]             out_target_address,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [63:0]             cfg_data
);

  cfg_t       cfg_r;
  logic       accept;
  logic       ent_push, mid_full, mid_empty, ent_pop;
  mid_entry_t ent_in, ent_out;
  logic       res_push, res_full;
  res_t       res_in, res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_MODE:    cfg_r.scan_mode    <= cfg_data[0];
        REG_REGION_BASE:  cfg_r.region_base  <= cfg_data;
        REG_MATCH_TARGET: cfg_r.match_target <= cfg_data;
        REG_RANGE_BASE:   cfg_r.range_base   <= cfg_data;
        REG_RANGE_SIZE:   cfg_r.range_size   <= cfg_data[31:0];
        REG_NTH_INDEX:    cfg_r.nth_index    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;

  rrs_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .code_byte (in_code_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg_r),
    .ent_push  (ent_push),
    .ent       (ent_in)
  );

  rrs_fifo #(.WIDTH($bits(mid_entry_t)), .DEPTH(MID_DEPTH_DEF)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ent_push),
    .din   (ent_in),
    .full  (mid_full),
    .pop   (ent_pop),
    .dout  (ent_out),
    .empty (mid_empty)
  );

  rrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ent_avail (!mid_empty),
    .ent       (ent_out),
    .ent_pop   (ent_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  rrs_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH_DEF)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_found          = res_out.found;
  assign out_instr_address  = res_out.instr_address;
  assign out_target_address = res_out.target_address;

endmodule

// ===== verif/tb_rip_relative_reference_scan_unit.sv =====
// Testbench for rip_relative_reference_scan_unit: byte streams with RIP-relative
// LEA/MOV sequences, checked in order against a built-in scan predictor.
// Depends on rrs_pkg and the RTL top level only.
module tb_rip_relative_reference_scan_unit;
  import rrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEM_GOAL = 700;
  localparam int unsigned PHASE_BYTES = 60;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [POS_BITS_DEF-1:0] POS_SATURATED = '1;

  typedef logic [7:0] code_q_t[$];

  // Tracks register copies and stream state, predicts each stream's result.
  class rip_scan_tracker;
    logic                    load_mode;
    logic [63:0]             region_base;
    logic [63:0]             match_target;
    logic [63:0]             range_base;
    logic [31:0]             range_size;
    logic [15:0]             nth_index;
    logic [47:0]             window;
    logic [POS_BITS_DEF-1:0] position;
    logic [15:0]             hit_count;
    logic                    stream_done;
    res_t                    expected_hits[$];
    int                      mismatches;

    function new();
      load_mode = 1'b0;
      region_base = '0;
      match_target = '0;
      range_base = '0;
      range_size = '0;
      nth_index = '0;
      mismatches = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      window = '0;
      position = '0;
      hit_count = '0;
      stream_done = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] d);
      case (idx)
        REG_SCAN_MODE: load_mode = d[0];
        REG_REGION_BASE: region_base = d;
        REG_MATCH_TARGET: match_target = d;
        REG_RANGE_BASE: range_base = d;
        REG_RANGE_SIZE: range_size = d[31:0];
        REG_NTH_INDEX: nth_index = d[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [7:0]  rex;
      logic [7:0]  opc;
      logic [7:0]  modrm;
      logic [31:0] disp;
      logic [63:0] ia;
      logic [63:0] tg;
      logic        hit;
      res_t        r;
      hit = 1'b0;
      ia = '0;
      tg = '0;
      if (stream_done) begin
        if (last) restart_stream();
        return;
      end
      if (!last && position >= WINDOW_LAG && position < POS_SATURATED) begin
        rex = window[7:0];
        opc = window[15:8];
        modrm = window[23:16];
        if ((rex == REX_W || rex == REX_WR) &&
            (opc == OPC_LEA || (load_mode && opc == OPC_MOV)) &&
            modrm[7:6] == MODRM_MOD0 && modrm[2:0] == MODRM_RIP) begin
          disp = {b, window[47:24]};
          ia = region_base + 64'(position - POS_BITS_DEF'(WINDOW_LAG));
          tg = ia + 64'(INSTR_LEN) + {{32{disp[31]}}, disp};
          if (!load_mode) begin
            hit = (tg == match_target);
          end else if ((tg - range_base) < {32'b0, range_size}) begin
            if (hit_count == nth_index) hit = 1'b1;
            else hit_count = hit_count + 16'd1;
          end
        end
      end
      window = {b, window[47:8]};
      if (position < POS_SATURATED) position = position + 1'b1;
      if (hit) begin
        r.found = 1'b1;
        r.instr_address = ia;
        r.target_address = tg;
        expected_hits.push_back(r);
        if (last) restart_stream();
        else stream_done = 1'b1;
      end else if (last) begin
        r = '0;
        expected_hits.push_back(r);
        restart_stream();
      end
    endfunction

    function void check_result(logic found, logic [63:0] ia, logic [63:0] ta);
      res_t want;
      if (expected_hits.size() == 0) begin
        $error("unexpected result: found %0d instr_address %h target_address %h",
               found, ia, ta);
        mismatches++;
        return;
      end
      want = expected_hits.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        mismatches++;
      end
      if (ia !== want.instr_address) begin
        $error("instr_address: expected %h, got %h", want.instr_address, ia);
        mismatches++;
      end
      if (ta !== want.target_address) begin
        $error("target_address: expected %h, got %h", want.target_address, ta);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_push;
  logic                    in_full;
  logic [7:0]              in_code_byte;
  logic                    in_last_byte;
  logic                    out_empty;
  logic                    out_pop;
  logic                    out_found;
  logic [63:0]             out_instr_address;
  logic [63:0]             out_target_address;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [63:0]             cfg_data;

  rip_scan_tracker sb;
  logic            steady;
  int unsigned     bytes_sent;
  int unsigned     cycle_count;

  rip_relative_reference_scan_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_code_byte(in_code_byte),
    .in_last_byte(in_last_byte),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_found(out_found),
    .out_instr_address(out_instr_address),
    .out_target_address(out_target_address),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: pop decisions at the falling edge, checks at the rising edge
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        sb.check_result(out_found, out_instr_address, out_target_address);
      @(negedge clk);
      out_pop = steady || ($urandom_range(99) >= 28);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 28) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_code_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (in_full);
    sb.take_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream(input code_q_t code);
    foreach (code[i]) push_byte(code[i], i == code.size() - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    in_push = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic pick_config(input int phase);
    logic        mode;
    logic [63:0] region;
    logic [63:0] target;
    logic [63:0] rbase;
    logic [31:0] rsize;
    logic [15:0] nth;
    mode = 1'($urandom_range(1));
    case ($urandom_range(4))
      0: region = '0;
      1: region = 64'hFFFF_FFFF_FFFF_FFC0;  // stream wraps past the top
      2: region = '1;
      3: region = 64'h0000_0001_4000_0000;
      default: region = {$urandom, $urandom};
    endcase
    case ($urandom_range(7))
      0: target = '0;
      1: target = '1;
      default: target = region + 64'($urandom_range(8191)) - 64'd4096;
    endcase
    case ($urandom_range(7))
      0: rbase = '0;
      1: rbase = 64'hFFFF_FFFF_FFFF_FF00;
      2: rbase = {$urandom, $urandom};
      default: rbase = region + 64'($urandom_range(8191)) - 64'd4096;
    endcase
    case ($urandom_range(7))
      0: rsize = '0;
      1: rsize = 32'd1;
      2: rsize = '1;
      default: rsize = $urandom_range(1, 8192);
    endcase
    case ($urandom_range(9))
      0: nth = '1;
      1: nth = 16'($urandom);
      default: nth = 16'($urandom_range(3));
    endcase
    if (phase == 1) begin
      mode = 1'b1;
      region = '1;
      target = '1;
      rbase = '1;
      rsize = '1;
      nth = '1;
    end else if (phase == 2) begin
      mode = 1'b0;
      region = '0;
      target = '0;
      rbase = '0;
      rsize = '0;
      nth = '0;
    end
    // upper bits beyond each register's width are junk and must be dropped
    write_reg(REG_SCAN_MODE, {63'({$urandom, $urandom}), mode});
    write_reg(REG_REGION_BASE, region);
    write_reg(REG_MATCH_TARGET, target);
    write_reg(REG_RANGE_BASE, rbase);
    write_reg(REG_RANGE_SIZE, {$urandom, rsize});
    write_reg(REG_NTH_INDEX, {48'({$urandom, $urandom}), nth});
    if ($urandom_range(2) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
  endtask

  task automatic random_stream();
    code_q_t     code;
    int          len;
    int          n_ins;
    int          p;
    int          k;
    logic [63:0] ia;
    logic [63:0] goal;
    logic [31:0] disp;
    k = $urandom_range(99);
    if (k < 8) len = $urandom_range(1, 7);
    else if (k < 15) len = $urandom_range(41, 80);
    else len = $urandom_range(8, 40);
    for (int i = 0; i < len; i++) code.push_back(8'($urandom));
    n_ins = (len >= INSTR_LEN && $urandom_range(9) != 0) ? $urandom_range(1, 1 + len / 8) : 0;
    for (int n = 0; n < n_ins; n++) begin
      p = ($urandom_range(4) == 0) ? len - INSTR_LEN : $urandom_range(0, len - INSTR_LEN);
      ia = sb.region_base + 64'(p);
      k = $urandom_range(99);
      if (k < 10) begin
        case ($urandom_range(3))
          0: disp = 32'h7FFF_FFFF;
          1: disp = 32'h8000_0000;
          2: disp = 32'h0000_0000;
          default: disp = 32'hFFFF_FFFF;
        endcase
      end else if (k < 75) begin
        if (!sb.load_mode) goal = sb.match_target;
        else if (k < 60 && sb.range_size != 0)
          goal = sb.range_base + ({32'b0, $urandom} % {32'b0, sb.range_size});
        else if (k < 65) goal = sb.range_base + {32'b0, sb.range_size} - 64'd1;
        else if (k < 70) goal = sb.range_base + {32'b0, sb.range_size};
        else goal = sb.range_base - 64'd1;
        disp = 32'(goal - ia - 64'(INSTR_LEN));
      end else begin
        disp = $urandom;
      end
      code[p] = $urandom_range(1) ? REX_W : REX_WR;
      code[p + 1] = (($urandom_range(1) && sb.load_mode) || $urandom_range(9) == 0) ?
                    OPC_MOV : OPC_LEA;
      code[p + 2] = {MODRM_MOD0, 3'($urandom), MODRM_RIP};
      {code[p + 6], code[p + 5], code[p + 4], code[p + 3]} = disp;
      // broken sequence: flip one bit in prefix, opcode or ModRM
      if ($urandom_range(99) < 15)
        code[p + $urandom_range(2)] ^= 8'(1 << $urandom_range(7));
    end
    send_stream(code);
  endtask

  initial begin
    code_q_t code;
    int      phase;
    sb = new();
    steady = 1'b0;
    bytes_sent = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_code_byte = '0;
    in_last_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SCAN_MODE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // registers at reset: exact mode, everything zero, so disp -7 at offset 0 hits
    code = '{8'h48, 8'h8D, 8'h05, 8'hF9, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_stream(code);
    // instruction ending on the last byte is never checked
    code = '{8'h48, 8'h8D, 8'h05, 8'hF9, 8'hFF, 8'hFF, 8'hFF};
    send_stream(code);
    // match, then a trailing byte that must stay silent
    code = '{8'h4C, 8'h8D, 8'h3D, 8'hF9, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_stream(code);
    code = '{8'hFF};
    send_stream(code);
    drain();

    phase = 1;
    while (bytes_sent < ITEM_GOAL) begin
      pick_config(phase);
      steady = (phase == 5 || phase == 6);
      begin
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) random_stream();
      end
      drain();
      phase++;
    end
    steady = 1'b0;
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
